// ===== sv/vg3d_pkg.sv =====
// vg3d_pkg: shared constants, types and helpers for the volume gradient block
// no dependencies; imported by vg3d_ctrl/calc/outq and volume_gradient_3d
package vg3d_pkg;

    localparam int MAX_X = 64;
    localparam int MAX_Y = 64;
    localparam int MAX_Z = 1024;

    // ring spans two planes plus two rows
    localparam int RING_DEPTH = 2 * MAX_X * MAX_Y + 2 * MAX_X;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int WORD_W     = 17;

    localparam int SX_W    = 7;
    localparam int SY_W    = 7;
    localparam int SZ_W    = 11;
    localparam int X_W     = $clog2(MAX_X);
    localparam int Y_W     = $clog2(MAX_Y);
    localparam int Z_W     = $clog2(MAX_Z);
    localparam int PLANE_W = $clog2(MAX_X * MAX_Y) + 1;
    localparam int GRAD_W  = 18;
    localparam int LEVEL_W = 3;

    localparam logic OP_VOXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] REG_SIZE_X  = 2'd0;
    localparam logic [1:0] REG_SIZE_Y  = 2'd1;
    localparam logic [1:0] REG_SIZE_Z  = 2'd2;
    localparam logic [1:0] REG_MASK_EN = 2'd3;

    localparam logic [SX_W-1:0] SIZE_X_RESET = SX_W'(MAX_X);
    localparam logic [SY_W-1:0] SIZE_Y_RESET = SY_W'(MAX_Y);
    localparam logic [SZ_W-1:0] SIZE_Z_RESET = SZ_W'(MAX_Z);

    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic               x_lo;
        logic               x_hi;
        logic               y_lo;
        logic               y_hi;
        logic               z_lo;
        logic               z_hi;
        logic signed [15:0] z_plus;
    } issue_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [GRAD_W-1:0] grad_z;
        logic                     in_mask;
        logic                     last;
    } result_t;

    function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] ptr,
                                                    input logic [PLANE_W-1:0] off);
        logic [RING_AW:0] sum;
        sum = {1'b0, ptr} + (RING_AW+1)'(off);
        if (sum >= (RING_AW+1)'(RING_DEPTH)) begin
            sum = sum - (RING_AW+1)'(RING_DEPTH);
        end
        return sum[RING_AW-1:0];
    endfunction

    function automatic logic [RING_AW-1:0] ring_sub(input logic [RING_AW-1:0] ptr,
                                                    input logic [PLANE_W-1:0] off);
        logic [RING_AW:0] diff;
        diff = {1'b0, ptr} - (RING_AW+1)'(off);
        if ({1'b0, ptr} < (RING_AW+1)'(off)) begin
            diff = diff + (RING_AW+1)'(RING_DEPTH);
        end
        return diff[RING_AW-1:0];
    endfunction

    // one axis in half units: one-sided at the faces, central inside
    function automatic logic signed [GRAD_W-1:0] axis_grad(input logic lo,
                                                           input logic hi,
                                                           input logic signed [15:0] c,
                                                           input logic signed [15:0] m,
                                                           input logic signed [15:0] p);
        logic signed [GRAD_W-1:0] cs;
        logic signed [GRAD_W-1:0] ms;
        logic signed [GRAD_W-1:0] ps;
        cs = {{(GRAD_W-16){c[15]}}, c};
        ms = {{(GRAD_W-16){m[15]}}, m};
        ps = {{(GRAD_W-16){p[15]}}, p};
        if (lo) begin
            return (ps - cs) <<< 1;
        end
        if (hi) begin
            return (cs - ms) <<< 1;
        end
        return ps - ms;
    endfunction

endpackage

// ===== sv/vg3d_ram.sv =====
// vg3d_ram: generic synchronous ram, one write port, two registered read ports
// no dependencies
module vg3d_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8320
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== sv/vg3d_ctrl.sv =====
// vg3d_ctrl: register port, raster counters, ring pointers and neighbour read issue
// depends on vg3d_pkg
module vg3d_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    input  logic                            voxel_valid,
    output logic                            voxel_stall,
    input  logic                            operation,
    input  logic signed [15:0]              sample,
    input  logic signed [15:0]              mask_sample,
    input  logic [vg3d_pkg::LEVEL_W-1:0]    q_level,
    output logic                            ring_we,
    output logic [vg3d_pkg::RING_AW-1:0]    ring_waddr,
    output logic [vg3d_pkg::WORD_W-1:0]     ring_wdata,
    output logic [vg3d_pkg::RING_AW-1:0]    addr_xp,
    output logic [vg3d_pkg::RING_AW-1:0]    addr_yp,
    output logic [vg3d_pkg::RING_AW-1:0]    addr_ym,
    output logic [vg3d_pkg::RING_AW-1:0]    addr_zm,
    output vg3d_pkg::issue_t                issue,
    output logic [vg3d_pkg::WORD_W-1:0]     first_word,
    output logic                            mask_en
);
    import vg3d_pkg::*;

    logic [SX_W-1:0]    size_x_reg;
    logic [SY_W-1:0]    size_y_reg;
    logic [SZ_W-1:0]    size_z_reg;
    logic               mask_en_reg;
    logic [X_W-1:0]     in_x_reg, in_x_next;
    logic [Y_W-1:0]     in_y_reg, in_y_next;
    logic [Z_W-1:0]     in_z_reg, in_z_next;
    logic [X_W-1:0]     out_x_reg, out_x_next;
    logic [Y_W-1:0]     out_y_reg, out_y_next;
    logic [Z_W-1:0]     out_z_reg, out_z_next;
    logic [PLANE_W-1:0] gap_reg, gap_next;
    logic               all_in_reg, all_in_next;
    logic [RING_AW-1:0] wp_reg, wp_next;
    logic [RING_AW-1:0] rp_reg, rp_next;
    issue_t             issue_reg, issue_next;
    logic [WORD_W-1:0]  first_reg;

    logic [SX_W-1:0]    sx, sx_m1;
    logic [SY_W-1:0]    sy, sy_m1;
    logic [SZ_W-1:0]    sz, sz_m1;
    logic [PLANE_W-1:0] plane;
    logic [PLANE_W-1:0] gap1;
    logic               cfg_wr, size_wr;
    logic               accept, take, emit, in_end, all_in1, out_last;
    logic               in_first, pos;
    logic               ox_hi, oy_hi, oz_hi;

    assign cfg_wr  = psel && penable && pwrite;
    assign size_wr = cfg_wr && (paddr[3:2] == REG_SIZE_X || paddr[3:2] == REG_SIZE_Y
                                || paddr[3:2] == REG_SIZE_Z);

    always_comb
    begin
        case (paddr[3:2])
            REG_SIZE_X:  prdata = 32'(size_x_reg);
            REG_SIZE_Y:  prdata = 32'(size_y_reg);
            REG_SIZE_Z:  prdata = 32'(size_z_reg);
            REG_MASK_EN: prdata = 32'(mask_en_reg);
            default:     prdata = '0;
        endcase
    end

    // clamp sizes into their legal ranges
    always_comb
    begin
        sx = size_x_reg;
        if (size_x_reg < SX_W'(2)) begin
            sx = SX_W'(2);
        end else if (size_x_reg > SX_W'(MAX_X)) begin
            sx = SX_W'(MAX_X);
        end
        sy = size_y_reg;
        if (size_y_reg < SY_W'(2)) begin
            sy = SY_W'(2);
        end else if (size_y_reg > SY_W'(MAX_Y)) begin
            sy = SY_W'(MAX_Y);
        end
        sz = size_z_reg;
        if (size_z_reg < SZ_W'(2)) begin
            sz = SZ_W'(2);
        end else if (size_z_reg > SZ_W'(MAX_Z)) begin
            sz = SZ_W'(MAX_Z);
        end
    end

    assign sx_m1 = sx - SX_W'(1);
    assign sy_m1 = sy - SY_W'(1);
    assign sz_m1 = sz - SZ_W'(1);
    assign plane = PLANE_W'(sx) * PLANE_W'(sy);

    // queue level plus the item in flight must leave room for one more result
    assign voxel_stall = ({1'b0, q_level} + (LEVEL_W+1)'(issue_reg.valid))
                         >= (LEVEL_W+1)'(3);

    assign accept   = voxel_valid && !voxel_stall;
    assign take     = accept && (operation == OP_VOXEL) && !all_in_reg;
    assign in_end   = ({1'b0, in_x_reg} == sx_m1) && ({1'b0, in_y_reg} == sy_m1)
                      && ({1'b0, in_z_reg} == sz_m1);
    assign in_first = (in_x_reg == '0) && (in_y_reg == '0) && (in_z_reg == '0);
    assign gap1     = gap_reg + PLANE_W'(take);
    assign all_in1  = all_in_reg || (take && in_end);
    assign emit     = accept && (gap1 != '0) && ((gap1 > plane) || all_in1);
    assign ox_hi    = ({1'b0, out_x_reg} == sx_m1);
    assign oy_hi    = ({1'b0, out_y_reg} == sy_m1);
    assign oz_hi    = ({1'b0, out_z_reg} == sz_m1);
    assign out_last = ox_hi && oy_hi && oz_hi;
    assign pos      = (mask_sample > 16'sd0);

    assign ring_we    = take;
    assign ring_waddr = wp_reg;
    assign ring_wdata = {pos, sample};

    assign addr_xp = ring_add(rp_reg, PLANE_W'(1));
    assign addr_yp = ring_add(rp_reg, PLANE_W'(sx));
    assign addr_ym = ring_sub(rp_reg, PLANE_W'(sx));
    assign addr_zm = ring_sub(rp_reg, plane);

    always_comb
    begin
        in_x_next   = in_x_reg;
        in_y_next   = in_y_reg;
        in_z_next   = in_z_reg;
        out_x_next  = out_x_reg;
        out_y_next  = out_y_reg;
        out_z_next  = out_z_reg;
        gap_next    = gap1 - PLANE_W'(emit);
        all_in_next = all_in1;
        wp_next     = wp_reg;
        rp_next     = rp_reg;

        issue_next        = issue_reg;
        issue_next.valid  = emit;
        issue_next.first  = (out_x_reg == '0) && (out_y_reg == '0) && (out_z_reg == '0);
        issue_next.last   = out_last;
        issue_next.x_lo   = (out_x_reg == '0);
        issue_next.x_hi   = ox_hi;
        issue_next.y_lo   = (out_y_reg == '0);
        issue_next.y_hi   = oy_hi;
        issue_next.z_lo   = (out_z_reg == '0);
        issue_next.z_hi   = oz_hi;
        issue_next.z_plus = sample;

        if (take) begin
            wp_next = (wp_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_reg + RING_AW'(1);
            if ({1'b0, in_x_reg} == sx_m1) begin
                in_x_next = '0;
                if ({1'b0, in_y_reg} == sy_m1) begin
                    in_y_next = '0;
                    in_z_next = in_z_reg + Z_W'(1);
                end else begin
                    in_y_next = in_y_reg + Y_W'(1);
                end
            end else begin
                in_x_next = in_x_reg + X_W'(1);
            end
        end

        if (emit) begin
            rp_next = (rp_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : rp_reg + RING_AW'(1);
            if (ox_hi) begin
                out_x_next = '0;
                if (oy_hi) begin
                    out_y_next = '0;
                    out_z_next = out_z_reg + Z_W'(1);
                end else begin
                    out_y_next = out_y_reg + Y_W'(1);
                end
            end else begin
                out_x_next = out_x_reg + X_W'(1);
            end
        end

        // end of volume or a new size: start over
        if (size_wr || (emit && out_last)) begin
            in_x_next   = '0;
            in_y_next   = '0;
            in_z_next   = '0;
            out_x_next  = '0;
            out_y_next  = '0;
            out_z_next  = '0;
            gap_next    = '0;
            all_in_next = 1'b0;
            wp_next     = '0;
            rp_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            size_x_reg      <= SIZE_X_RESET;
            size_y_reg      <= SIZE_Y_RESET;
            size_z_reg      <= SIZE_Z_RESET;
            mask_en_reg     <= 1'b0;
            in_x_reg        <= '0;
            in_y_reg        <= '0;
            in_z_reg        <= '0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_z_reg       <= '0;
            gap_reg         <= '0;
            all_in_reg      <= 1'b0;
            wp_reg          <= '0;
            rp_reg          <= '0;
            issue_reg       <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_SIZE_X:  size_x_reg  <= pwdata[SX_W-1:0];
                    REG_SIZE_Y:  size_y_reg  <= pwdata[SY_W-1:0];
                    REG_SIZE_Z:  size_z_reg  <= pwdata[SZ_W-1:0];
                    REG_MASK_EN: mask_en_reg <= pwdata[0];
                    default:     ;
                endcase
            end
            in_x_reg        <= in_x_next;
            in_y_reg        <= in_y_next;
            in_z_reg        <= in_z_next;
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            out_z_reg       <= out_z_next;
            gap_reg         <= gap_next;
            all_in_reg      <= all_in_next;
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            issue_reg       <= issue_next;
        end
    end

    // copy of the origin voxel for the first result of a volume
    always_ff @(posedge clk)
    begin
        if (take && in_first) begin
            first_reg <= ring_wdata;
        end
    end

    assign issue      = issue_reg;
    assign first_word = first_reg;
    assign mask_en    = mask_en_reg;

endmodule

// ===== sv/vg3d_calc.sv =====
// vg3d_calc: x neighbour chain and the three axis differences with mask gating
// depends on vg3d_pkg
module vg3d_calc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vg3d_pkg::issue_t            issue,
    input  logic [vg3d_pkg::WORD_W-1:0] first_word,
    input  logic                        mask_en,
    input  logic [vg3d_pkg::WORD_W-1:0] rd_xp,
    input  logic [vg3d_pkg::WORD_W-1:0] rd_yp,
    input  logic [vg3d_pkg::WORD_W-1:0] rd_ym,
    input  logic [vg3d_pkg::WORD_W-1:0] rd_zm,
    output logic                        push,
    output vg3d_pkg::result_t           push_data
);
    import vg3d_pkg::*;

    // next_reg holds the word read as the right neighbour by the previous voxel
    logic [WORD_W-1:0] next_reg;
    logic [WORD_W-1:0] cen_reg;
    logic [WORD_W-1:0] center;
    logic              counted;

    assign center  = issue.first ? first_word : next_reg;
    assign counted = mask_en ? center[WORD_W-1] : 1'b1;

    always_ff @(posedge clk)
    begin
        if (issue.valid) begin
            next_reg <= rd_xp;
            cen_reg  <= center;
        end
    end

    assign push = issue.valid;

    always_comb
    begin
        push_data.in_mask = counted;
        push_data.last    = issue.last;
        push_data.grad_x  = '0;
        push_data.grad_y  = '0;
        push_data.grad_z  = '0;
        if (counted) begin
            push_data.grad_x = axis_grad(issue.x_lo, issue.x_hi, center[15:0],
                                         cen_reg[15:0], rd_xp[15:0]);
            push_data.grad_y = axis_grad(issue.y_lo, issue.y_hi, center[15:0],
                                         rd_ym[15:0], rd_yp[15:0]);
            push_data.grad_z = axis_grad(issue.z_lo, issue.z_hi, center[15:0],
                                         rd_zm[15:0], issue.z_plus);
        end
    end

    logic unused_rst;
    assign unused_rst = rst_n;

endmodule

// ===== sv/vg3d_outq.sv =====
// vg3d_outq: four-entry result queue parting the compute stage from the consumer
// depends on vg3d_pkg
module vg3d_outq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  vg3d_pkg::result_t               push_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output vg3d_pkg::result_t               head,
    output logic [vg3d_pkg::LEVEL_W-1:0]    level
);
    import vg3d_pkg::*;

    result_t                entry [4];
    logic [1:0]             wr_ptr_reg;
    logic [1:0]             rd_ptr_reg;
    logic [LEVEL_W-1:0]     count_reg;
    logic                   pop;

    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign head         = entry[rd_ptr_reg];
    assign level        = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + LEVEL_W'(push) - LEVEL_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/volume_gradient_3d.sv =====
// volume_gradient_3d: streaming 3d gradient (central, one-sided at faces), two-plane ring
// result_valid follows the releasing item through the issue register and the result queue
// throughput: one item per cycle unless voxel_stall, set by two dual-read ring memories;
// a voxel result is released once size_x*size_y+1 voxels are in, the rest by later items
// reset: counters and pointers cleared, sizes 64/64/1024, masking off, ring left unset
// depends on vg3d_pkg, vg3d_ram, vg3d_ctrl, vg3d_calc, vg3d_outq
module volume_gradient_3d (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                voxel_valid,
    output logic                                voxel_stall,
    input  logic                                operation,
    input  logic signed [15:0]                  sample,
    input  logic signed [15:0]                  mask_sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [vg3d_pkg::GRAD_W-1:0]  grad_x,
    output logic signed [vg3d_pkg::GRAD_W-1:0]  grad_y,
    output logic signed [vg3d_pkg::GRAD_W-1:0]  grad_z,
    output logic                                in_mask,
    output logic                                last
);
    import vg3d_pkg::*;

    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr;
    logic [WORD_W-1:0]  ring_wdata;
    logic [RING_AW-1:0] addr_xp, addr_yp, addr_ym, addr_zm;
    logic [WORD_W-1:0]  rd_xp, rd_yp, rd_ym, rd_zm;
    issue_t             issue;
    logic [WORD_W-1:0]  first_word;
    logic               mask_en;
    logic [LEVEL_W-1:0] q_level;
    logic               push;
    result_t            push_data;
    result_t            head;

    assign pready = 1'b1;

    vg3d_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .voxel_valid (voxel_valid),
        .voxel_stall (voxel_stall),
        .operation   (operation),
        .sample      (sample),
        .mask_sample (mask_sample),
        .q_level     (q_level),
        .ring_we     (ring_we),
        .ring_waddr  (ring_waddr),
        .ring_wdata  (ring_wdata),
        .addr_xp     (addr_xp),
        .addr_yp     (addr_yp),
        .addr_ym     (addr_ym),
        .addr_zm     (addr_zm),
        .issue       (issue),
        .first_word  (first_word),
        .mask_en     (mask_en)
    );

    // two copies of the ring so four neighbours come back each cycle
    vg3d_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_ring_a (
        .clk     (clk),
        .we      (ring_we),
        .waddr   (ring_waddr),
        .wdata   (ring_wdata),
        .raddr_a (addr_xp),
        .raddr_b (addr_yp),
        .rdata_a (rd_xp),
        .rdata_b (rd_yp)
    );

    vg3d_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_ring_b (
        .clk     (clk),
        .we      (ring_we),
        .waddr   (ring_waddr),
        .wdata   (ring_wdata),
        .raddr_a (addr_ym),
        .raddr_b (addr_zm),
        .rdata_a (rd_ym),
        .rdata_b (rd_zm)
    );

    vg3d_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .first_word (first_word),
        .mask_en    (mask_en),
        .rd_xp      (rd_xp),
        .rd_yp      (rd_yp),
        .rd_ym      (rd_ym),
        .rd_zm      (rd_zm),
        .push       (push),
        .push_data  (push_data)
    );

    vg3d_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head),
        .level        (q_level)
    );

    assign grad_x  = head.grad_x;
    assign grad_y  = head.grad_y;
    assign grad_z  = head.grad_z;
    assign in_mask = head.in_mask;
    assign last    = head.last;

`ifndef SYNTHESIS
    // queue plus the item in flight never exceed the room kept by the stall
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, q_level} + (LEVEL_W+1)'(issue.valid)) <= (LEVEL_W+1)'(3))
        else $error("result queue overrun");

    assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid && issue.last |-> issue.x_hi && issue.y_hi && issue.z_hi)
        else $error("last flag away from the far corner");

    assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid && issue.first |-> issue.x_lo && issue.y_lo && issue.z_lo)
        else $error("first voxel away from the origin");
`endif

endmodule

// ===== verif/volume_gradient_3d_checker.sv =====
// checker for volume_gradient_3d: watches the register port and both item channels,
// predicts each gradient result and compares it with what the block delivers
// depends on vg3d_pkg
`timescale 1ns / 1ps

module volume_gradient_3d_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    input  logic                               voxel_valid,
    input  logic                               voxel_stall,
    input  logic                               operation,
    input  logic signed [15:0]                 sample,
    input  logic signed [15:0]                 mask_sample,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  logic signed [vg3d_pkg::GRAD_W-1:0] grad_x,
    input  logic signed [vg3d_pkg::GRAD_W-1:0] grad_y,
    input  logic signed [vg3d_pkg::GRAD_W-1:0] grad_z,
    input  logic                               in_mask,
    input  logic                               last,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 result_count
);
    import vg3d_pkg::*;

    logic [WORD_W-1:0] voxel_store [RING_DEPTH];
    logic [SX_W-1:0]   sx_reg;
    logic [SY_W-1:0]   sy_reg;
    logic [SZ_W-1:0]   sz_reg;
    logic              mask_on;
    int                n_in;
    int                n_out;
    int                wr_ptr;
    int                px;
    int                py;
    int                pz;
    result_t           gradient_queue [$];

    function automatic int clamp_extent(int v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int stored_sample(int pos);
        logic signed [15:0] w;
        w = voxel_store[pos % RING_DEPTH][15:0];
        return int'(w);
    endfunction

    function automatic int half_unit_diff(int p, int stride, int coord, int extent);
        int c;
        c = stored_sample(p);
        if (coord == 0) return 2 * (stored_sample(p + stride) - c);
        if (coord >= extent - 1) return 2 * (c - stored_sample(p - stride));
        return stored_sample(p + stride) - stored_sample(p - stride);
    endfunction

    task automatic clear_position();
        n_in   = 0;
        n_out  = 0;
        wr_ptr = 0;
        px     = 0;
        py     = 0;
        pz     = 0;
    endtask

    task automatic predict_gradient(logic op, logic signed [15:0] s, logic signed [15:0] m);
        int      sx;
        int      sy;
        int      sz;
        int      plane;
        int      total;
        logic    counted;
        result_t r;
        sx    = clamp_extent(int'(sx_reg), MAX_X);
        sy    = clamp_extent(int'(sy_reg), MAX_Y);
        sz    = clamp_extent(int'(sz_reg), MAX_Z);
        plane = sx * sy;
        total = plane * sz;
        if (op == OP_VOXEL && n_in < total) begin
            voxel_store[wr_ptr] = {(m > 0), s};
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            n_in++;
        end
        if (n_out >= n_in) return;
        if (!(n_out + plane < n_in || n_in >= total)) return;
        counted   = mask_on ? voxel_store[n_out % RING_DEPTH][16] : 1'b1;
        r.grad_x  = '0;
        r.grad_y  = '0;
        r.grad_z  = '0;
        r.in_mask = counted;
        r.last    = (n_out + 1 == total);
        if (counted) begin
            r.grad_x = GRAD_W'(half_unit_diff(n_out, 1, px, sx));
            r.grad_y = GRAD_W'(half_unit_diff(n_out, sx, py, sy));
            r.grad_z = GRAD_W'(half_unit_diff(n_out, plane, pz, sz));
        end
        gradient_queue.push_back(r);
        if (r.last) begin
            clear_position();
        end else begin
            n_out++;
            px++;
            if (px >= sx) begin
                px = 0;
                py++;
                if (py >= sy) begin
                    py = 0;
                    pz++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            sx_reg  = SIZE_X_RESET;
            sy_reg  = SIZE_Y_RESET;
            sz_reg  = SIZE_Z_RESET;
            mask_on = 1'b0;
            clear_position();
            gradient_queue.delete();
            fail_count   = 0;
            result_count = 0;
        end else begin
            if (result_valid && !result_stall) begin
                result_count++;
                if (gradient_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: %0d %0d %0d m %0b l %0b",
                                 grad_x, grad_y, grad_z, in_mask, last);
                end else begin
                    want = gradient_queue.pop_front();
                    if (want.grad_x !== grad_x || want.grad_y !== grad_y ||
                        want.grad_z !== grad_z || want.in_mask !== in_mask ||
                        want.last !== last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %0d %0d %0d %0b %0b got %0d %0d %0d %0b %0b",
                                     want.grad_x, want.grad_y, want.grad_z, want.in_mask,
                                     want.last, grad_x, grad_y, grad_z, in_mask, last);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SIZE_X:  begin sx_reg = pwdata[SX_W-1:0]; clear_position(); end
                    REG_SIZE_Y:  begin sy_reg = pwdata[SY_W-1:0]; clear_position(); end
                    REG_SIZE_Z:  begin sz_reg = pwdata[SZ_W-1:0]; clear_position(); end
                    REG_MASK_EN: mask_on = pwdata[0];
                    default: ;
                endcase
            end
            if (voxel_valid && !voxel_stall)
                predict_gradient(operation, sample, mask_sample);
        end
        pending = gradient_queue.size();
    end

endmodule

// ===== verif/tb_volume_gradient_3d.sv =====
// testbench top for volume_gradient_3d: reset, register writes, directed and random
// volumes under varying idle and stall patterns; verdict from volume_gradient_3d_checker
// depends on vg3d_pkg, volume_gradient_3d and volume_gradient_3d_checker
`timescale 1ns / 1ps

module tb_volume_gradient_3d;
    import vg3d_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [3:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     voxel_valid;
    logic                     voxel_stall;
    logic                     operation;
    logic signed [15:0]       sample;
    logic signed [15:0]       mask_sample;
    logic                     result_valid;
    logic                     result_stall;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic                     in_mask;
    logic                     last;

    int fail_count;
    int pending;
    int result_count;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int items_sent;
    int volumes;

    volume_gradient_3d dut (.*);

    volume_gradient_3d_checker chk (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[volume_gradient_3d] ERROR");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            result_stall = 1'b1;
            hold_cycles--;
        end else begin
            result_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_item(logic op, logic [15:0] s, logic [15:0] m);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            voxel_valid = 1'b0;
            @(negedge clk);
        end
        voxel_valid = 1'b1;
        operation   = op;
        sample      = s;
        mask_sample = m;
        do @(posedge clk); while (voxel_stall);
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        voxel_valid = 1'b0;
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // all results in, then a wait for items still in flight
    task automatic drain();
        stop_sending();
        wait (pending == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic configure(int x, int y, int z, logic m);
        reg_write(REG_SIZE_X, ($urandom() & ~32'h7F) | x);
        reg_write(REG_SIZE_Y, ($urandom() & ~32'h7F) | y);
        reg_write(REG_SIZE_Z, ($urandom() & ~32'h7FF) | z);
        reg_write(REG_MASK_EN, ($urandom() & ~32'h1) | m);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_mask();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // one volume of voxels with stray flushes, then flushes to release the tail
    // unless broken; pause_at >= 0 stops the sender there until every result is in
    task automatic run_volume(int x, int y, int z, logic m, bit broken, int pause_at);
        int sx;
        int sy;
        int sz;
        int total;
        int stop_at;
        int n;
        sx = (x < 2) ? 2 : (x > MAX_X ? MAX_X : x);
        sy = (y < 2) ? 2 : (y > MAX_Y ? MAX_Y : y);
        sz = (z < 2) ? 2 : (z > MAX_Z ? MAX_Z : z);
        total   = sx * sy * sz;
        stop_at = broken ? $urandom_range(total - 1) : total;
        configure(x, y, z, m);
        n = 0;
        while (n < stop_at) begin
            if (n == pause_at) begin
                stop_sending();
                wait (pending == 0);
            end
            if ($urandom_range(15) == 0) begin
                send_item(OP_FLUSH, 16'($urandom()), 16'($urandom()));
            end else begin
                send_item(OP_VOXEL, pick_sample(), pick_mask());
                n++;
            end
        end
        if (!broken) begin
            // some extra voxels are dropped once the volume is complete
            for (int i = 0; i < sx * sy + 3; i++)
                send_item(($urandom_range(3) == 0) ? OP_VOXEL : OP_FLUSH,
                          16'($urandom()), 16'($urandom()));
        end
        drain();
        volumes++;
    endtask

    initial begin
        int x;
        int y;
        int z;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        voxel_valid    = 1'b0;
        operation      = OP_VOXEL;
        sample         = '0;
        mask_sample    = '0;
        result_stall   = 1'b0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        items_sent     = 0;
        volumes        = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: smallest volume, full-scale samples, masking off then on
        configure(2, 2, 2, 1'b0);
        for (int i = 0; i < 8; i++)
            send_item(OP_VOXEL, (i % 3 == 0) ? 16'h7FFF : 16'h8000, 16'h0000);
        for (int i = 0; i < 6; i++)
            send_item(OP_FLUSH, 16'hFFFF, 16'hFFFF);
        drain();
        reg_write(REG_MASK_EN, 32'd1);
        send_item(OP_VOXEL, 16'h8000, 16'h0000);
        send_item(OP_VOXEL, 16'h7FFF, 16'h0001);
        send_item(OP_VOXEL, 16'h0000, 16'hFFFF);
        send_item(OP_VOXEL, 16'hFFFF, 16'h7FFF);
        send_item(OP_VOXEL, 16'h7FFF, 16'h8000);
        send_item(OP_VOXEL, 16'h8000, 16'h0001);
        send_item(OP_FLUSH, 16'h0000, 16'h0000);
        send_item(OP_VOXEL, 16'h0001, 16'h0002);
        send_item(OP_VOXEL, 16'h8000, 16'h0001);
        for (int i = 0; i < 6; i++)
            send_item(OP_FLUSH, 16'h0000, 16'h0000);
        drain();

        // extremes of the extents, including clamped register values
        run_volume(64, 2, 2, 1'b0, 0, -1);
        run_volume(2, 64, 2, 1'b1, 0, -1);
        run_volume(127, 0, 1, 1'b0, 0, -1);
        run_volume(1, 2, 0, 1'b1, 0, -1);

        while (items_sent < 1900) begin
            case (volumes % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (volumes == 8)
                hold_cycles = 400;
            if ($urandom_range(9) == 0) begin
                x = $urandom_range(127);
                y = $urandom_range(3);
                z = $urandom_range(3);
            end else begin
                x = $urandom_range(6, 2);
                y = $urandom_range(5, 2);
                z = $urandom_range(5, 2);
            end
            run_volume(x, y, z, $urandom_range(1), ($urandom_range(9) == 0),
                       (volumes == 10) ? 4 : -1);
        end

        $display("covered %0d volumes, %0d items in, %0d results out",
                 volumes, items_sent, result_count);
        $display("extents 2 to 64, clamped sizes, masking, broken volumes, long hold-off");
        if (fail_count == 0 && pending == 0)
            $display("[volume_gradient_3d] OK");
        else
            $display("[volume_gradient_3d] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/vg3d_pkg.sv
sv/vg3d_ram.sv
sv/vg3d_ctrl.sv
sv/vg3d_calc.sv
sv/vg3d_outq.sv
sv/volume_gradient_3d.sv
verif/volume_gradient_3d_checker.sv
verif/tb_volume_gradient_3d.sv
